### rtl/core/aqi_piecewise_linear_index_top_defines.svh
// Assertion macros shared by the air quality index block.
// No dependencies; included by the top level only.
`ifndef AQI_PIECEWISE_LINEAR_INDEX_TOP_DEFINES_SVH
`define AQI_PIECEWISE_LINEAR_INDEX_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define AQI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define AQI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/aqi_pkg.sv
// Shared constants, types and reset table for the air quality index block.
// No dependencies; used by aqi_ctrl, aqi_dpath and the top level.
package aqi_pkg;

    localparam int NUM_SEG    = 6;
    localparam int FRAC_BITS  = 8;
    localparam int SAMPLE_W   = 16;
    localparam int FIELD_W    = 16;
    localparam int WORD_W     = 4 * FIELD_W;
    localparam int INDEX_W    = 24;
    localparam int SEG_W      = 3;
    localparam int SEL_W      = (NUM_SEG > 1) ? $clog2(NUM_SEG) : 1;
    localparam int CFG_REGS   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    // Divider sizing: numerator is |dI*dx| shifted up by the fraction bits
    localparam int PROD_W    = 2 * FIELD_W;
    localparam int NUM_W     = PROD_W + FRAC_BITS;
    localparam int DIV_STEPS = (NUM_W + 1) / 2;
    localparam int DIVD_W    = 2 * DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int SUM_W     = DIVD_W + 2;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_seg_table [NUM_SEG];

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIX,
        S_SEND
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic fix;
        logic send;
    } t_cmd;

    typedef struct packed {
        logic held;
        logic div_last;
        logic out_free;
    } t_status;

    // Reset breakpoint table (integer PM2.5 breakpoints and index bounds)
    function automatic t_word seg_default(input int k);
        t_word w;
        case (k)
            0:       w = 64'd14073748836319232;
            1:       w = 64'd28147716716691469;
            2:       w = 64'd42221680301899812;
            3:       w = 64'd56295643892023352;
            4:       w = 64'd84443356318007447;
            5:       w = 64'd140738781173252347;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/aqi_ctrl.sv
// Sequencer for the air quality index block: load, multiply, divide, fix, send.
// Depends on aqi_pkg; drives aqi_dpath through command and status structs.
module aqi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  aqi_pkg::t_status  i_status,
    output aqi_pkg::t_cmd     o_cmd
);
    import aqi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = i_status.held ? S_SEND : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) n_state = S_FIX;
            end
            S_FIX: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL: begin
                o_cmd.mul = !i_status.held;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
            end
            S_SEND: begin
                o_cmd.send = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/aqi_dpath.sv
// Datapath: segment search, slope product, radix-4 restoring divider,
// result fix-up, last-result state and output register. Depends on aqi_pkg.
module aqi_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  aqi_pkg::t_cmd                  i_cmd,
    output aqi_pkg::t_status               o_status,
    input  aqi_pkg::t_seg_table            i_seg_tab,
    input  logic [aqi_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [aqi_pkg::INDEX_W-1:0]    o_index,
    output logic [aqi_pkg::SEG_W-1:0]      o_seg,
    output logic                           o_clamped,
    output logic                           o_held
);
    import aqi_pkg::*;

    // ---------------- load stage: segment search and clamp
    logic             w_found;
    logic [SEL_W-1:0] w_sel;
    logic             w_clamp;
    t_word            w_last_word;

    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        if (i_sample <= i_seg_tab[0][2*FIELD_W-1:FIELD_W]) begin
            w_found = 1'b1;
        end
        for (int k = 1; k < NUM_SEG - 1; k++) begin
            if (!w_found && i_sample >= i_seg_tab[k][FIELD_W-1:0]
                    && i_sample <= i_seg_tab[k][2*FIELD_W-1:FIELD_W]) begin
                w_found = 1'b1;
                w_sel   = SEL_W'(k);
            end
        end
        if (!w_found) w_sel = SEL_W'(NUM_SEG - 1);
    end

    assign w_last_word = i_seg_tab[NUM_SEG-1];
    assign w_clamp     = !w_found && (i_sample > w_last_word[2*FIELD_W-1:FIELD_W]);

    logic [FIELD_W-1:0] r_x;
    t_word              r_word;
    logic [SEL_W-1:0]   r_sel;
    logic               r_clamp;
    logic               r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (i_cmd.load) begin
            r_held <= (i_sample == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= w_clamp ? w_last_word[2*FIELD_W-1:FIELD_W] : i_sample;
            r_word  <= i_seg_tab[w_sel];
            r_sel   <= w_sel;
            r_clamp <= w_clamp;
        end
    end

    // ---------------- multiply stage: signed differences to magnitudes
    logic [FIELD_W-1:0] w_lo, w_hi, w_ilo, w_ihi;
    logic [FIELD_W:0]   w_di, w_dx, w_den;
    logic [FIELD_W-1:0] w_di_mag, w_dx_mag, w_den_mag;
    logic [PROD_W-1:0]  w_prod;

    assign w_lo  = r_word[FIELD_W-1:0];
    assign w_hi  = r_word[2*FIELD_W-1:FIELD_W];
    assign w_ilo = r_word[3*FIELD_W-1:2*FIELD_W];
    assign w_ihi = r_word[4*FIELD_W-1:3*FIELD_W];

    assign w_di  = {1'b0, w_ihi} - {1'b0, w_ilo};
    assign w_dx  = {1'b0, r_x} - {1'b0, w_lo};
    assign w_den = {1'b0, w_hi} - {1'b0, w_lo};

    assign w_di_mag  = w_di[FIELD_W]  ? FIELD_W'(-w_di)  : w_di[FIELD_W-1:0];
    assign w_dx_mag  = w_dx[FIELD_W]  ? FIELD_W'(-w_dx)  : w_dx[FIELD_W-1:0];
    assign w_den_mag = w_den[FIELD_W] ? FIELD_W'(-w_den) : w_den[FIELD_W-1:0];
    assign w_prod    = w_di_mag * w_dx_mag;

    // ---------------- divider: two quotient bits per cycle
    logic [DIVD_W-1:0]  r_divd;
    logic [FIELD_W-1:0] r_den;
    logic [FIELD_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_neg;
    logic               r_den_zero;

    logic [FIELD_W:0]   w_den_ext;
    logic [FIELD_W:0]   w_t1, w_t2;
    logic               w_ge1, w_ge2;
    logic [FIELD_W-1:0] w_rem1, w_rem2;

    assign w_den_ext = {1'b0, r_den};
    assign w_t1   = {r_rem, r_divd[DIVD_W-1]};
    assign w_ge1  = (w_t1 >= w_den_ext);
    assign w_rem1 = w_ge1 ? FIELD_W'(w_t1 - w_den_ext) : w_t1[FIELD_W-1:0];
    assign w_t2   = {w_rem1, r_divd[DIVD_W-2]};
    assign w_ge2  = (w_t2 >= w_den_ext);
    assign w_rem2 = w_ge2 ? FIELD_W'(w_t2 - w_den_ext) : w_t2[FIELD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_divd     <= DIVD_W'(w_prod) << FRAC_BITS;
            r_den      <= w_den_mag;
            r_rem      <= '0;
            r_cnt      <= '0;
            r_neg      <= w_di[FIELD_W] ^ w_dx[FIELD_W] ^ w_den[FIELD_W];
            r_den_zero <= (w_den == '0);
        end else if (i_cmd.step) begin
            r_divd <= {r_divd[DIVD_W-3:0], w_ge1, w_ge2};
            r_rem  <= w_rem2;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // ---------------- fix stage: sign, offset, floor and saturate
    logic [SUM_W-1:0]   w_q_ext, w_q_sgn, w_base, w_sum;
    logic [INDEX_W-1:0] w_result;

    assign w_q_ext = r_den_zero ? '0 : SUM_W'(r_divd);
    assign w_q_sgn = r_neg ? (~w_q_ext + 1'b1) : w_q_ext;
    assign w_base  = SUM_W'(w_ilo) << FRAC_BITS;
    assign w_sum   = w_q_sgn + w_base;

    always_comb begin
        if (w_sum[SUM_W-1]) begin
            w_result = '0;
        end else if (|w_sum[SUM_W-2:INDEX_W]) begin
            w_result = INDEX_MAX;
        end else begin
            w_result = w_sum[INDEX_W-1:0];
        end
    end

    logic [INDEX_W-1:0] r_last_index;
    logic [SEL_W-1:0]   r_last_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index <= '0;
            r_last_seg   <= '0;
        end else if (i_cmd.fix) begin
            r_last_index <= w_result;
            r_last_seg   <= r_sel;
        end
    end

    // ---------------- output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.send) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send) begin
            o_index   <= r_last_index;
            o_seg     <= SEG_W'(r_last_seg);
            o_clamped <= r_clamp && !r_held;
            o_held    <= r_held;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.held     = r_held;
    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

### rtl/core/aqi_piecewise_linear_index_top.sv
// Top level of the air quality index block: config registers, port packing.
// Depends on aqi_pkg, aqi_ctrl, aqi_dpath and the assertion macro header.
//
//  Port group  | Direction | Payload                           | Handshake
//  ------------+-----------+-----------------------------------+---------------------------
//  cfg         | in        | index 3b, data 64b (one segment)  | i_cfg_valid / o_cfg_ready
//  s_axis      | in        | raw_sample 16b                    | s_axis_tvalid / tready
//  m_axis      | out       | index, segment, clamp/held flags  | m_axis_tvalid / tready
//
// A non-zero reading passes from accept through the multiply state, the divider
// steps and the fix state to the output register; the restoring divider retires
// two quotient bits per cycle over a 40-bit numerator. A zero reading skips the
// divider and repeats the last result. The next request is taken in the cycle
// after a result enters the output register, while that result waits there, so
// only one reading is in flight. Synchronous active-low reset restores the PM2.5
// table and clears the last result to zero. A stalled output only holds the
// sequencer in its send state.

`include "aqi_piecewise_linear_index_top_defines.svh"

module aqi_piecewise_linear_index_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [aqi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aqi_pkg::WORD_W-1:0]       i_cfg_data,
    // reading input: [15:0] raw_sample
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [aqi_pkg::SAMPLE_W-1:0]     s_axis_tdata,
    // result output: [23:0] index_value, [26:24] segment_used, [31:27] zero
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [aqi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // result flags: [0] was_clamped, [1] was_held
    output logic [aqi_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import aqi_pkg::*;

    // Segment registers; segments past the register list stay at reset value
    t_seg_table r_seg_tab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SEG; k++) begin
                r_seg_tab[k] <= seg_default(k);
            end
        end else begin
            for (int k = 0; k < NUM_SEG; k++) begin
                if (i_cfg_valid && k < CFG_REGS && i_cfg_index == CFG_IDX_W'(k)) begin
                    r_seg_tab[k] <= i_cfg_data;
                end
            end
        end
    end

    // Writes are registered directly; always take them
    assign o_cfg_ready = 1'b1;

    t_cmd    w_cmd;
    t_status w_status;

    logic [INDEX_W-1:0] w_index;
    logic [SEG_W-1:0]   w_seg;
    logic               w_clamped;
    logic               w_held;

    aqi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    aqi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_seg_tab   (r_seg_tab),
        .i_sample    (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_index     (w_index),
        .o_seg       (w_seg),
        .o_clamped   (w_clamped),
        .o_held      (w_held)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = OUT_DATA_W'({w_seg, w_index});
    assign m_axis_tuser = {w_held, w_clamped};

    // One request at a time: the sequencer leaves idle after every accept
    `AQI_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an item is in flight")

    // Clamping happens only on the top segment and never on a repeated result
    `AQI_ASSERT_SAME(a_clamp_top_seg, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[26:24] == SEG_W'(NUM_SEG - 1)) && !m_axis_tuser[1], "clamp flag on wrong segment or on held result")

    // A send command must present a result on the next cycle
    `AQI_ASSERT_NEXT(a_send_shows, i_clk, i_rst_n, w_cmd.send, m_axis_tvalid, "send issued but no result presented")

endmodule

### tb/sv/tb_aqi_piecewise_linear_index_top.sv
// Self-checking bench for aqi_piecewise_linear_index_top: streams raw readings in,
// predicts each index result and compares it field by field against the block output.
// Depends on aqi_pkg and the RTL top level only.

module tb_aqi_piecewise_linear_index_top;

    import aqi_pkg::*;

    // Timeout, in clock cycles.
    localparam int    CYCLE_LIMIT = 800000;
    // Quiet cycles before the block is taken as idle
    localparam int    IDLE_CYCLES = 40;
    // Output requests after which the receiver holds off for a long stretch
    localparam int    HOLD_AT_A   = 60;
    localparam int    HOLD_AT_B   = 520;
    localparam int    LONG_HOLD   = 300;
    localparam longint SCALE      = longint'(1) << FRAC_BITS;
    localparam longint INDEX_CEIL = (longint'(1) << INDEX_W) - 1;

    // Register indexes of the configuration channel; the two spares are ignored
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEG_ONE,
        REG_SEG_TWO,
        REG_SEG_THREE,
        REG_SEG_FOUR,
        REG_SEG_FIVE,
        REG_SEG_SIX,
        REG_SPARE_LO,
        REG_SPARE_HI
    } aqi_reg_e;

    // Breakpoint tables that a test round loads
    typedef enum logic [2:0] {
        TBL_PM25,
        TBL_RAMP,
        TBL_NOISE,
        TBL_ZERO,
        TBL_ONES
    } tbl_kind_e;

    typedef struct packed {
        logic [INDEX_W-1:0] index_value;
        logic [SEG_W-1:0]   segment_used;
        logic               was_clamped;
        logic               was_held;
    } aqi_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [WORD_W-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // Predictor state: segment table and the last computed result
    logic [WORD_W-1:0]     seg_tbl [NUM_SEG];
    logic [INDEX_W-1:0]    last_index;
    logic [SEG_W-1:0]      last_segment;

    logic [SAMPLE_W-1:0]   reading_q [$];    // readings waiting to be offered
    aqi_result_t           pending_aqi [$];  // predicted results, oldest first

    int mismatches   = 0;
    int cycle_count  = 0;
    int send_gap     = 0;
    int send_calm    = 0;
    int recv_gap     = 0;
    int recv_calm    = 0;
    int results_seen = 0;

    // Integer PM2.5 table that the block restores at reset
    logic [WORD_W-1:0] pm25_words [NUM_SEG] = '{
        64'd14073748836319232,
        64'd28147716716691469,
        64'd42221680301899812,
        64'd56295643892023352,
        64'd84443356318007447,
        64'd140738781173252347
    };

    // Directed readings against the PM2.5 table: segment edges, both ends of the
    // field, the clamp above the top breakpoint and a zero before any result
    logic [SAMPLE_W-1:0] pm25_probes [13] = '{
        16'd0, 16'd1, 16'd12, 16'd13, 16'd35, 16'd55, 16'd150,
        16'd250, 16'd500, 16'd501, 16'hFFFF, 16'h5555, 16'hAAAA
    };

    // Directed readings against the corner-case table loaded in the second phase
    logic [SAMPLE_W-1:0] corner_probes [13] = '{
        16'd1, 16'd20, 16'd21, 16'd100, 16'd101, 16'd150, 16'd200,
        16'd250, 16'd301, 16'd40000, 16'd40001, 16'hFFFF, 16'd0
    };

    // Test plan after the directed part: one table per round, then random readings
    tbl_kind_e round_kind  [9] = '{TBL_PM25, TBL_RAMP, TBL_ZERO, TBL_NOISE, TBL_RAMP,
                                   TBL_ONES, TBL_PM25, TBL_NOISE, TBL_RAMP};
    int        round_items [9] = '{150, 130, 20, 130, 130, 20, 150, 130, 130};

    aqi_piecewise_linear_index_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    // A calm stretch forces back-to-back activity for a while.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] pack_seg(input int bp_lo, input int bp_hi,
                                                   input int idx_lo, input int idx_hi);
        return {idx_hi[15:0], idx_lo[15:0], bp_hi[15:0], bp_lo[15:0]};
    endfunction

    // Expected result for one reading; updates the last-result state like the block.
    function automatic aqi_result_t aqi_of_reading(input logic [SAMPLE_W-1:0] reading);
        aqi_result_t       res;
        logic [WORD_W-1:0] w;
        longint            x, bp_lo, bp_hi, idx_lo, idx_hi, span, quot, acc;
        int                seg, k;
        res = '0;
        // Zero means no reading: repeat the last result, state untouched
        if (reading == '0) begin
            res.index_value  = last_index;
            res.segment_used = last_segment;
            res.was_held     = 1'b1;
            return res;
        end
        x   = reading;
        seg = -1;
        bp_hi = seg_tbl[0][31:16];
        if (x <= bp_hi) seg = 0;
        for (k = 1; k < NUM_SEG - 1; k++) begin
            if (seg < 0) begin
                bp_lo = seg_tbl[k][15:0];
                bp_hi = seg_tbl[k][31:16];
                if (x >= bp_lo && x <= bp_hi) seg = k;
            end
        end
        // Fall through to the top segment; clamp above its high breakpoint
        if (seg < 0) begin
            seg   = NUM_SEG - 1;
            bp_hi = seg_tbl[seg][31:16];
            if (x > bp_hi) begin
                x               = bp_hi;
                res.was_clamped = 1'b1;
            end
        end
        w      = seg_tbl[seg];
        bp_lo  = w[15:0];
        bp_hi  = w[31:16];
        idx_lo = w[47:32];
        idx_hi = w[63:48];
        span   = bp_hi - bp_lo;
        quot   = 0;
        // Signed division truncates toward zero; a zero-width segment gives its low index
        if (span != 0) quot = ((idx_hi - idx_lo) * (x - bp_lo) * SCALE) / span;
        acc = quot + idx_lo * SCALE;
        if (acc < 0) acc = 0;
        if (acc > INDEX_CEIL) acc = INDEX_CEIL;
        last_index       = acc[INDEX_W-1:0];
        last_segment     = SEG_W'(seg);
        res.index_value  = last_index;
        res.segment_used = last_segment;
        return res;
    endfunction

    // Random reading: zeros, values around the current breakpoints, the PM2.5
    // range where the default table lives, and the full field.
    function automatic logic [SAMPLE_W-1:0] pick_reading();
        logic [WORD_W-1:0] w;
        int                r;
        r = $urandom_range(0, 99);
        w = seg_tbl[$urandom_range(0, NUM_SEG - 1)];
        if (r < 8) return '0;
        if (r < 30) begin
            case ($urandom_range(0, 3))
                0:       return w[15:0];
                1:       return w[31:16];
                2:       return w[15:0] - 16'd1;
                default: return w[31:16] + 16'd1;
            endcase
        end
        if (r < 75) return SAMPLE_W'($urandom_range(1, 600));
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // Sender: offer queued readings, hold while stalled, predict on each accept.
    always @(posedge i_clk) begin : reading_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_aqi.push_back(aqi_of_reading(s_axis_tdata));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the request until the block takes it
            end else if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (reading_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= reading_q.pop_front();
                send_gap       = pick_gap(send_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: random stalls, plus two long holds while the
    // sender keeps offering, so the output register fills and input stalls.
    always @(posedge i_clk) begin : ready_driver
        int gap;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) begin
                    recv_gap = LONG_HOLD;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                gap = pick_gap(recv_calm);
                if (gap > 0) begin
                    recv_gap       = gap - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each accepted result against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        aqi_result_t want;
        aqi_result_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.index_value  = m_axis_tdata[INDEX_W-1:0];
            got.segment_used = m_axis_tdata[INDEX_W +: SEG_W];
            got.was_clamped  = m_axis_tuser[0];
            got.was_held     = m_axis_tuser[1];
            if (pending_aqi.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end else begin
                want = pending_aqi.pop_front();
                if (got.index_value !== want.index_value) begin
                    mismatches++;
                    $display("%0t: index_value expected %h got %h",
                             $time, want.index_value, got.index_value);
                end
                if (got.segment_used !== want.segment_used) begin
                    mismatches++;
                    $display("%0t: segment_used expected %0d got %0d",
                             $time, want.segment_used, got.segment_used);
                end
                if (got.was_clamped !== want.was_clamped) begin
                    mismatches++;
                    $display("%0t: was_clamped expected %b got %b",
                             $time, want.was_clamped, got.was_clamped);
                end
                if (got.was_held !== want.was_held) begin
                    mismatches++;
                    $display("%0t: was_held expected %b got %b",
                             $time, want.was_held, got.was_held);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("aqi_piecewise_linear_index_top regression: fail");
            $finish;
        end
    end

    // Write one register; called at a rising edge and returns at one.
    // Drop valid for a cycle afterwards so back-to-back writes stay clean.
    task automatic write_reg(input aqi_reg_e idx, input logic [WORD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx < NUM_SEG) seg_tbl[idx] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until no reading is queued or offered and every result has come,
    // then for a stretch longer than one reading's latency.
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < IDLE_CYCLES) begin
            @(posedge i_clk);
            if (reading_q.size() == 0 && !s_axis_tvalid && pending_aqi.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic load_table(input tbl_kind_e kind);
        logic [WORD_W-1:0] w;
        int                k, bp_lo, bp_hi, idx_lo, idx_hi;
        bp_hi  = -1;
        idx_hi = 0;
        for (k = 0; k < CFG_REGS; k++) begin
            case (kind)
                TBL_PM25:  w = pm25_words[k];
                TBL_ZERO:  w = '0;
                TBL_ONES:  w = '1;
                TBL_NOISE: w = {$urandom, $urandom};
                default: begin
                    // Ascending breakpoints and indexes; segments may touch or be zero width
                    bp_lo  = (bp_hi + 1 > 65535) ? 65535 : bp_hi + 1;
                    bp_hi  = bp_lo + $urandom_range(0, 3000);
                    if (bp_hi > 65535) bp_hi = 65535;
                    idx_lo = idx_hi;
                    idx_hi = idx_lo + $urandom_range(0, 200);
                    if (idx_hi > 65535) idx_hi = 65535;
                    w = pack_seg(bp_lo, bp_hi, idx_lo, idx_hi);
                end
            endcase
            write_reg(aqi_reg_e'(k), w);
        end
        // Spare indexes must leave the table alone
        if (kind == TBL_NOISE) begin
            write_reg(REG_SPARE_LO, {$urandom, $urandom});
            write_reg(REG_SPARE_HI, {$urandom, $urandom});
        end
    endtask

    initial begin : stimulus
        int n, i;
        for (i = 0; i < NUM_SEG; i++) seg_tbl[i] = pm25_words[i];
        last_index    = '0;
        last_segment  = '0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_SEG_ONE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed readings against the reset table
        foreach (pm25_probes[i]) reading_q.push_back(pm25_probes[i]);
        wait_idle();

        // Corner-case table: reversed breakpoints that saturate, a zero-width
        // segment, a falling index, a segment no reading can hit, and a top
        // segment that goes negative below its low breakpoint and clamps above
        write_reg(REG_SEG_ONE,   pack_seg(50, 20, 0, 16'hFFFF));
        write_reg(REG_SEG_TWO,   pack_seg(100, 100, 16'hFFFF, 0));
        write_reg(REG_SEG_THREE, pack_seg(200, 300, 16'hFFFF, 0));
        write_reg(REG_SEG_FOUR,  pack_seg(301, 40000, 0, 16'hFFFF));
        write_reg(REG_SEG_FIVE,  pack_seg(0, 0, 16'h1234, 16'h4321));
        write_reg(REG_SEG_SIX,   pack_seg(150, 250, 5, 300));
        foreach (corner_probes[i]) reading_q.push_back(corner_probes[i]);
        wait_idle();

        // Random rounds, each with its own table
        for (n = 0; n < 9; n++) begin
            load_table(round_kind[n]);
            for (i = 0; i < round_items[n]; i++) reading_q.push_back(pick_reading());
            wait_idle();
        end

        if (mismatches == 0 && pending_aqi.size() == 0) begin
            $display("aqi_piecewise_linear_index_top regression: pass");
        end else begin
            $display("aqi_piecewise_linear_index_top regression: fail");
        end
        $finish;
    end

endmodule

### aqi_piecewise_linear_index_top.f
+incdir+rtl/core
rtl/core/aqi_pkg.sv
rtl/core/aqi_ctrl.sv
rtl/core/aqi_dpath.sv
rtl/core/aqi_piecewise_linear_index_top.sv
tb/sv/tb_aqi_piecewise_linear_index_top.sv
